// ===== rtl/scar_pkg.sv =====
package scar_pkg;

   // Default build constants.
   localparam int COMB_DEPTH_DEF    = 8192;
   localparam int LEFT_AP1_LEN_DEF  = 96;
   localparam int RIGHT_AP1_LEN_DEF = 120;
   localparam int LEFT_AP2_LEN_DEF  = 48;
   localparam int RIGHT_AP2_LEN_DEF = 72;
   localparam int SAMPLE_BITS_DEF   = 24;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_COMB_LEN_ONE   = 3'd0;
   localparam logic [2:0] REG_COMB_LEN_TWO   = 3'd1;
   localparam logic [2:0] REG_COMB_LEN_THREE = 3'd2;
   localparam logic [2:0] REG_COMB_LEN_FOUR  = 3'd3;
   localparam logic [2:0] REG_DAMPING        = 3'd4;
   localparam logic [2:0] REG_DRY_GAIN       = 3'd5;
   localparam logic [2:0] REG_WET_GAIN       = 3'd6;

   // Register reset values and limits.
   localparam logic [13:0] COMB_LEN_RST_ONE   = 14'd2640;
   localparam logic [13:0] COMB_LEN_RST_TWO   = 14'd2904;
   localparam logic [13:0] COMB_LEN_RST_THREE = 14'd3432;
   localparam logic [13:0] COMB_LEN_RST_FOUR  = 14'd3960;
   localparam logic [15:0] DAMP_RST  = 16'd13107;
   localparam logic [15:0] DAMP_MAX  = 16'd58982;
   localparam logic [16:0] GAIN_RST  = 17'd32768;
   localparam logic [16:0] GAIN_UNITY = 17'd65536;

   // Comb input weights in Q16: 1, 0.7, 0.5 and 0.2.
   localparam logic [16:0] COMB_WEIGHT_ONE   = 17'd65536;
   localparam logic [16:0] COMB_WEIGHT_TWO   = 17'd45875;
   localparam logic [16:0] COMB_WEIGHT_THREE = 17'd32768;
   localparam logic [16:0] COMB_WEIGHT_FOUR  = 17'd13107;

   // Width of the allpass data path; holds any chain value.
   localparam int AP_XW = 36;

   // Sequencer strobes shared by the comb and allpass units.
   typedef struct packed {
      logic rd;       // read the entry at the current position
      logic mul;      // register the feedback product
      logic wr;       // write back and advance the position
      logic pos_rst;  // return the position to zero
   } scar_ctl_type;

   // Address width of a memory of the given depth.
   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic int max_of(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== rtl/scar_ram.sv =====
module scar_ram
   import scar_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [addr_bits(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       re,
   input  logic [addr_bits(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/scar_comb.sv =====
module scar_comb
   import scar_pkg::*;
#(
   parameter int          DEPTH  = COMB_DEPTH_DEF,
   parameter int          SB     = SAMPLE_BITS_DEF,
   parameter logic [16:0] WEIGHT = COMB_WEIGHT_ONE
) (
   input  logic                        clock,
   input  logic                        reset,
   input  scar_ctl_type                ctl,
   input  logic                        clr_we,
   input  logic [addr_bits(DEPTH)-1:0] clr_addr,
   input  logic [13:0]                 len_raw,
   input  logic [15:0]                 damp,
   input  logic signed [SB-1:0]        mono,
   output logic signed [31:0]          value
);

   localparam int AW = addr_bits(DEPTH);
   localparam int LW = AW + 1;

   logic [LW-1:0]        eff_len;
   logic [AW-1:0]        pos_ff;
   logic [AW-1:0]        pos_cur;
   logic [AW-1:0]        pos_nxt;
   logic [LW-1:0]        pos_inc;
   logic                 len_one;
   logic signed [31:0]   rdata;
   logic signed [SB+17:0] wprod;
   logic signed [SB+17:0] wq;
   logic signed [33:0]   w_ff;
   logic signed [48:0]   dprod_ff;
   logic signed [48:0]   dq;
   logic signed [34:0]   upd;
   logic signed [31:0]   upd_sat;
   logic signed [31:0]   new_ff;
   logic                 we;
   logic [AW-1:0]        waddr;
   logic [31:0]          wdata;
   logic                 re;
   logic [AW-1:0]        raddr;

   // Effective length: zero acts as one, anything above the depth as the depth.
   always_comb begin
      if (len_raw == 14'd0) begin
         eff_len = LW'(1);
      end else if (32'(len_raw) > 32'(DEPTH)) begin
         eff_len = LW'(DEPTH);
      end else begin
         eff_len = LW'(len_raw);
      end
   end

   assign len_one = (eff_len == LW'(1));
   assign pos_cur = ({1'b0, pos_ff} >= eff_len) ? '0 : pos_ff;
   assign pos_inc = {1'b0, pos_cur} + LW'(1);
   assign pos_nxt = (pos_inc >= eff_len) ? '0 : pos_inc[AW-1:0];

   // Weighted mono input, rounded to nearest.
   assign wprod = mono * $signed({1'b0, WEIGHT});
   assign wq    = (wprod + (SB+18)'(32768)) >>> 16;

   // Rounded feedback term and saturated update.
   assign dq  = (dprod_ff + 49'sd32768) >>> 16;
   assign upd = 35'(w_ff) + 35'(dq);
   always_comb begin
      if (upd > 35'sd2147483647) begin
         upd_sat = 32'sh7fffffff;
      end else if (upd < -35'sd2147483648) begin
         upd_sat = 32'sh80000000;
      end else begin
         upd_sat = upd[31:0];
      end
   end

   // Position and data path registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (ctl.pos_rst) begin
         pos_ff <= '0;
      end else if (ctl.wr) begin
         pos_ff <= pos_nxt;
      end
      if (ctl.rd) begin
         w_ff <= 34'(wq);
      end
      if (ctl.mul) begin
         dprod_ff <= rdata * $signed({1'b0, damp});
      end
      if (ctl.wr) begin
         new_ff <= upd_sat;
      end
   end

   // Memory ports: the clear sweep owns the write port while it runs.
   assign we    = clr_we | ctl.wr;
   assign waddr = clr_we ? clr_addr : pos_cur;
   assign wdata = clr_we ? '0 : upd_sat;
   assign re    = ctl.rd | ctl.wr;
   assign raddr = ctl.wr ? pos_nxt : pos_cur;

   scar_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   // With length one the entry read back is the one just written.
   assign value = len_one ? new_ff : rdata;

endmodule

// ===== rtl/scar_allpass.sv =====
module scar_allpass
   import scar_pkg::*;
#(
   parameter int LEN = LEFT_AP1_LEN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  scar_ctl_type              ctl,
   input  logic                      clr_we,
   input  logic [addr_bits(LEN)-1:0] clr_addr,
   input  logic signed [AP_XW-1:0]   x,
   output logic signed [AP_XW-1:0]   y
);

   localparam int AW = addr_bits(LEN);

   logic [AW-1:0]            pos_ff;
   logic [AW-1:0]            pos_nxt;
   logic signed [31:0]       rdata;
   logic signed [AP_XW:0]    s_full;
   logic signed [31:0]       s_sat;
   logic signed [31:0]       s_ff;
   logic signed [AP_XW-1:0]  x_ff;
   logic                     we;
   logic [AW-1:0]            waddr;
   logic [31:0]              wdata;

   assign pos_nxt = (32'(pos_ff) + 1 >= LEN) ? '0 : AW'(32'(pos_ff) + 1);

   // s = x + round(store / 2), saturated to 32 bits.
   assign s_full = (AP_XW+1)'(x) + (AP_XW+1)'((33'(rdata) + 33'sd1) >>> 1);
   always_comb begin
      if (s_full > (AP_XW+1)'(33'sd2147483647)) begin
         s_sat = 32'sh7fffffff;
      end else if (s_full < (AP_XW+1)'(-33'sd2147483648)) begin
         s_sat = 32'sh80000000;
      end else begin
         s_sat = s_full[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (ctl.pos_rst) begin
         pos_ff <= '0;
      end else if (ctl.wr) begin
         pos_ff <= pos_nxt;
      end
      if (ctl.wr) begin
         s_ff <= s_sat;
         x_ff <= x;
      end
   end

   assign we    = clr_we | ctl.wr;
   assign waddr = clr_we ? clr_addr : pos_ff;
   assign wdata = clr_we ? '0 : s_sat;

   scar_ram #(.WIDTH(32), .DEPTH(LEN)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (ctl.rd),
      .raddr (pos_ff),
      .rdata (rdata)
   );

   // y = x - round(s / 2).
   assign y = x_ff - AP_XW'((33'(s_ff) + 33'sd1) >>> 1);

endmodule

// ===== rtl/stereo_comb_allpass_reverb_top.sv =====
// Channel   Ports                                   Direction
// req       req_valid, req_stall, req_*_sample      in
// rsp       rsp_valid, rsp_stall, rsp_*_out         out
// csr       csr_valid, csr_ready, csr_index, csr_data   in
//
// A word accepted in idle raises rsp_valid after comb read, feedback multiply,
// write back, comb sum, two allpass stages, chain capture, output multiply and
// output load; a result held under rsp_stall delays the load. A word is taken
// only in idle, once the last one is loaded; the single memory pass per word
// sets that. After reset a sweep over max(COMB_DEPTH, allpass lengths) addresses
// clears all delay memories, req_stall high; csr writes are taken at all times.
// A result waiting under rsp_stall holds the last sequencer step.
module stereo_comb_allpass_reverb_top
   import scar_pkg::*;
#(
   parameter int COMB_DEPTH    = COMB_DEPTH_DEF,
   parameter int LEFT_AP1_LEN  = LEFT_AP1_LEN_DEF,
   parameter int RIGHT_AP1_LEN = RIGHT_AP1_LEN_DEF,
   parameter int LEFT_AP2_LEN  = LEFT_AP2_LEN_DEF,
   parameter int RIGHT_AP2_LEN = RIGHT_AP2_LEN_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [16:0]                  csr_data
);

   localparam int SB      = SAMPLE_BITS;
   localparam int CLR_LEN = max_of(max_of(COMB_DEPTH, LEFT_AP1_LEN),
                                   max_of(RIGHT_AP1_LEN,
                                          max_of(LEFT_AP2_LEN, RIGHT_AP2_LEN)));
   localparam int CW      = $clog2(CLR_LEN + 1);
   localparam int OW      = 56;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_MUL, ST_WR, ST_SUM,
      ST_AP1, ST_AP2, ST_Y, ST_MULO, ST_OUT
   } state_type;

   state_type             state_ff;
   logic [CW-1:0]         clr_ff;
   logic                  clr_on;
   logic [13:0]           len_ff [4];
   logic [15:0]           damp_ff;
   logic [16:0]           dry_ff;
   logic [16:0]           wet_ff;
   logic [15:0]           damp_eff;
   logic [16:0]           dry_eff;
   logic [16:0]           wet_eff;
   logic                  csr_wr;
   logic                  len_wr;
   logic signed [SB-1:0]  l_ff;
   logic signed [SB-1:0]  r_ff;
   logic signed [SB-1:0]  mono_ff;
   logic signed [SB:0]    lr_sum;
   logic signed [31:0]    comb_val [4];
   logic signed [33:0]    sum_ff;
   logic signed [AP_XW-1:0] y_l1;
   logic signed [AP_XW-1:0] y_l2;
   logic signed [AP_XW-1:0] y_r1;
   logic signed [AP_XW-1:0] y_r2;
   logic signed [AP_XW-1:0] yl_ff;
   logic signed [AP_XW-1:0] yr_ff;
   logic signed [SB+17:0] dpl_ff;
   logic signed [SB+17:0] dpr_ff;
   logic signed [AP_XW+17:0] wpl_ff;
   logic signed [AP_XW+17:0] wpr_ff;
   logic signed [SB-1:0]  out_l;
   logic signed [SB-1:0]  out_r;
   logic                  rsp_valid_ff;
   logic signed [SB-1:0]  rsp_l_ff;
   logic signed [SB-1:0]  rsp_r_ff;
   scar_ctl_type          comb_ctl;
   scar_ctl_type          ap1_ctl;
   scar_ctl_type          ap2_ctl;

   // Configuration registers; the port never pushes back.
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign len_wr    = csr_wr & (csr_index == REG_COMB_LEN_ONE ||
                                csr_index == REG_COMB_LEN_TWO ||
                                csr_index == REG_COMB_LEN_THREE ||
                                csr_index == REG_COMB_LEN_FOUR);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff[0] <= COMB_LEN_RST_ONE;
         len_ff[1] <= COMB_LEN_RST_TWO;
         len_ff[2] <= COMB_LEN_RST_THREE;
         len_ff[3] <= COMB_LEN_RST_FOUR;
         damp_ff   <= DAMP_RST;
         dry_ff    <= GAIN_RST;
         wet_ff    <= GAIN_RST;
      end else if (csr_wr) begin
         case (csr_index)
            REG_COMB_LEN_ONE:   len_ff[0] <= csr_data[13:0];
            REG_COMB_LEN_TWO:   len_ff[1] <= csr_data[13:0];
            REG_COMB_LEN_THREE: len_ff[2] <= csr_data[13:0];
            REG_COMB_LEN_FOUR:  len_ff[3] <= csr_data[13:0];
            REG_DAMPING:        damp_ff   <= csr_data[15:0];
            REG_DRY_GAIN:       dry_ff    <= csr_data;
            REG_WET_GAIN:       wet_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign damp_eff = (damp_ff > DAMP_MAX) ? DAMP_MAX : damp_ff;
   assign dry_eff  = (dry_ff > GAIN_UNITY) ? GAIN_UNITY : dry_ff;
   assign wet_eff  = (wet_ff > GAIN_UNITY) ? GAIN_UNITY : wet_ff;

   // Mono sum, rounded toward minus infinity.
   assign lr_sum = (SB+1)'(req_left_sample) + (SB+1)'(req_right_sample);

   // Sequencer strobes for the units.
   assign clr_on = (state_ff == ST_CLEAR);
   always_comb begin
      comb_ctl         = '0;
      comb_ctl.rd      = (state_ff == ST_RD);
      comb_ctl.mul     = (state_ff == ST_MUL);
      comb_ctl.wr      = (state_ff == ST_WR);
      comb_ctl.pos_rst = len_wr;
      ap1_ctl          = '0;
      ap1_ctl.rd       = (state_ff == ST_RD);
      ap1_ctl.wr       = (state_ff == ST_AP1);
      ap1_ctl.pos_rst  = len_wr;
      ap2_ctl          = '0;
      ap2_ctl.rd       = (state_ff == ST_RD);
      ap2_ctl.wr       = (state_ff == ST_AP2);
   end

   // Output rounding and saturation.
   function automatic logic signed [SB-1:0] sat_out(input logic signed [OW-1:0] v);
      logic signed [OW-1:0] hi;
      logic signed [OW-1:0] lo;
      hi = OW'((64'sd1 <<< (SB - 1)) - 64'sd1);
      lo = -hi - OW'(1);
      if (v > hi) begin
         return hi[SB-1:0];
      end else if (v < lo) begin
         return lo[SB-1:0];
      end
      return v[SB-1:0];
   endfunction

   assign out_l = sat_out(OW'((dpl_ff + (SB+18)'(32768)) >>> 16) +
                          OW'((wpl_ff + (AP_XW+18)'(32768)) >>> 16));
   assign out_r = sat_out(OW'((dpr_ff + (SB+18)'(32768)) >>> 16) +
                          OW'((wpr_ff + (AP_XW+18)'(32768)) >>> 16));

   // State machine with the data path registers it steps.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A taken result frees the output register unless a new one loads now.
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (32'(clr_ff) == CLR_LEN - 1) begin
                  state_ff <= ST_IDLE;
               end
               clr_ff <= clr_ff + CW'(1);
            end
            ST_IDLE: begin
               if (req_valid) begin
                  l_ff     <= req_left_sample;
                  r_ff     <= req_right_sample;
                  mono_ff  <= lr_sum[SB:1];
                  state_ff <= ST_RD;
               end
            end
            ST_RD:  state_ff <= ST_MUL;
            ST_MUL: state_ff <= ST_WR;
            ST_WR:  state_ff <= ST_SUM;
            ST_SUM: begin
               sum_ff <= 34'(comb_val[0]) + 34'(comb_val[1]) +
                         34'(comb_val[2]) + 34'(comb_val[3]);
               state_ff <= ST_AP1;
            end
            ST_AP1: state_ff <= ST_AP2;
            ST_AP2: state_ff <= ST_Y;
            ST_Y: begin
               yl_ff    <= y_l2;
               yr_ff    <= y_r2;
               state_ff <= ST_MULO;
            end
            ST_MULO: begin
               dpl_ff   <= l_ff * $signed({1'b0, dry_eff});
               dpr_ff   <= r_ff * $signed({1'b0, dry_eff});
               wpl_ff   <= yl_ff * $signed({1'b0, wet_eff});
               wpr_ff   <= yr_ff * $signed({1'b0, wet_eff});
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_l_ff     <= out_l;
                  rsp_r_ff     <= out_r;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;

   // Four feedback combs.
   localparam logic [16:0] WEIGHTS [4] = '{COMB_WEIGHT_ONE, COMB_WEIGHT_TWO,
                                          COMB_WEIGHT_THREE, COMB_WEIGHT_FOUR};
   for (genvar k = 0; k < 4; k++) begin : g_comb
      scar_comb #(.DEPTH(COMB_DEPTH), .SB(SB), .WEIGHT(WEIGHTS[k])) u_comb (
         .clock    (clock),
         .reset    (reset),
         .ctl      (comb_ctl),
         .clr_we   (clr_on && 32'(clr_ff) < COMB_DEPTH),
         .clr_addr (clr_ff[addr_bits(COMB_DEPTH)-1:0]),
         .len_raw  (len_ff[k]),
         .damp     (damp_eff),
         .mono     (mono_ff),
         .value    (comb_val[k])
      );
   end

   // Two allpass chains, one per channel.
   scar_allpass #(.LEN(LEFT_AP1_LEN)) u_ap_l1 (
      .clock (clock), .reset (reset), .ctl (ap1_ctl),
      .clr_we   (clr_on && 32'(clr_ff) < LEFT_AP1_LEN),
      .clr_addr (clr_ff[addr_bits(LEFT_AP1_LEN)-1:0]),
      .x (AP_XW'(sum_ff)), .y (y_l1)
   );
   scar_allpass #(.LEN(LEFT_AP2_LEN)) u_ap_l2 (
      .clock (clock), .reset (reset), .ctl (ap2_ctl),
      .clr_we   (clr_on && 32'(clr_ff) < LEFT_AP2_LEN),
      .clr_addr (clr_ff[addr_bits(LEFT_AP2_LEN)-1:0]),
      .x (y_l1), .y (y_l2)
   );
   scar_allpass #(.LEN(RIGHT_AP1_LEN)) u_ap_r1 (
      .clock (clock), .reset (reset), .ctl (ap1_ctl),
      .clr_we   (clr_on && 32'(clr_ff) < RIGHT_AP1_LEN),
      .clr_addr (clr_ff[addr_bits(RIGHT_AP1_LEN)-1:0]),
      .x (AP_XW'(sum_ff)), .y (y_r1)
   );
   scar_allpass #(.LEN(RIGHT_AP2_LEN)) u_ap_r2 (
      .clock (clock), .reset (reset), .ctl (ap2_ctl),
      .clr_we   (clr_on && 32'(clr_ff) < RIGHT_AP2_LEN),
      .clr_addr (clr_ff[addr_bits(RIGHT_AP2_LEN)-1:0]),
      .x (y_r1), .y (y_r2)
   );

endmodule

// ===== rtl/scar_checker.sv =====
module scar_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_left_out,
   input logic [SAMPLE_BITS-1:0] rsp_right_out
);

   // The clearing sweep holds off input right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("input taken during memory clear");

   // Only one word is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while busy");

   // A result cannot appear the cycle after a word enters.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_out)
                                  && $stable(rsp_right_out))
      else $error("stalled result changed");

endmodule

bind stereo_comb_allpass_reverb_top scar_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_left_out  (rsp_left_out),
   .rsp_right_out (rsp_right_out)
);

// ===== tb/stereo_comb_allpass_reverb_top_tb.sv =====
module stereo_comb_allpass_reverb_top_tb;
   import scar_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW = SAMPLE_BITS_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef logic signed [SW-1:0] sample_type;
   typedef struct {
      sample_type left;
      sample_type right;
   } stereo_word_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   sample_type req_left_sample;
   sample_type req_right_sample;
   logic rsp_valid;
   logic rsp_stall;
   sample_type rsp_left_out;
   sample_type rsp_right_out;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [16:0] csr_data;

   stereo_comb_allpass_reverb_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_left_sample(req_left_sample), .req_right_sample(req_right_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_left_out(rsp_left_out), .rsp_right_out(rsp_right_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Reverb state mirrored from the block.
   int comb_mem [4][COMB_DEPTH_DEF];
   int comb_pos [4];
   int ap_mem [4][RIGHT_AP1_LEN_DEF];
   int ap_pos [4];
   int ap_len [4] = '{LEFT_AP1_LEN_DEF, LEFT_AP2_LEN_DEF,
                      RIGHT_AP1_LEN_DEF, RIGHT_AP2_LEN_DEF};
   longint comb_wt [4] = '{COMB_WEIGHT_ONE, COMB_WEIGHT_TWO, COMB_WEIGHT_THREE,
                           COMB_WEIGHT_FOUR};
   longint comb_len_reg [4];
   longint damp_reg;
   longint dry_reg;
   longint wet_reg;

   stereo_word_type pending_words [$];
   stereo_word_type expected_outs [$];
   int mismatches;
   int cycles;
   int send_gap;
   int stall_left;
   bit send_burst;
   bit stall_burst;
   logic next_valid;
   stereo_word_type next_word;
   stereo_word_type seen_word;

   // Q16 product, rounded to nearest with ties up.
   function automatic longint q16_mul(longint v, longint g);
      return (v * g + 32768) >>> 16;
   endfunction

   function automatic int clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   function automatic sample_type clip_sample(longint v);
      longint hi;
      hi = (64'sd1 <<< (SW - 1)) - 1;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return sample_type'(v);
   endfunction

   function automatic longint allpass_stage(int k, longint x);
      int p;
      int s;
      p = ap_pos[k];
      if (p >= ap_len[k]) p = 0;
      s = clip32(x + q16_mul(ap_mem[k][p], 32768));
      ap_mem[k][p] = s;
      p++;
      if (p >= ap_len[k]) p = 0;
      ap_pos[k] = p;
      return x - q16_mul(s, 32768);
   endfunction

   // Advance the mirrored reverb by one word and queue the expected output.
   function automatic void reverb_step(sample_type l, sample_type r);
      longint ls, rs, mono, damp, dg, wg, sum, lw, rw, len;
      int p;
      stereo_word_type res;
      ls = l;
      rs = r;
      mono = (ls + rs) >>> 1;
      damp = (damp_reg > DAMP_MAX) ? DAMP_MAX : damp_reg;
      dg = (dry_reg > GAIN_UNITY) ? GAIN_UNITY : dry_reg;
      wg = (wet_reg > GAIN_UNITY) ? GAIN_UNITY : wet_reg;
      sum = 0;
      for (int k = 0; k < 4; k++) begin
         len = comb_len_reg[k];
         if (len < 1) len = 1;
         if (len > COMB_DEPTH_DEF) len = COMB_DEPTH_DEF;
         p = comb_pos[k];
         if (p >= len) p = 0;
         comb_mem[k][p] = clip32(q16_mul(mono, comb_wt[k]) +
                                 q16_mul(comb_mem[k][p], damp));
         p++;
         if (p >= len) p = 0;
         comb_pos[k] = p;
         sum += comb_mem[k][p];
      end
      lw = allpass_stage(0, sum);
      lw = allpass_stage(1, lw);
      rw = allpass_stage(2, sum);
      rw = allpass_stage(3, rw);
      res.left = clip_sample(q16_mul(ls, dg) + q16_mul(lw, wg));
      res.right = clip_sample(q16_mul(rs, dg) + q16_mul(rw, wg));
      expected_outs.push_back(res);
   endfunction

   function automatic void apply_register(logic [2:0] idx, logic [16:0] data);
      case (idx)
         REG_COMB_LEN_ONE, REG_COMB_LEN_TWO, REG_COMB_LEN_THREE, REG_COMB_LEN_FOUR: begin
            comb_len_reg[idx[1:0]] = data[13:0];
            for (int k = 0; k < 4; k++) comb_pos[k] = 0;
            ap_pos[0] = 0;
            ap_pos[2] = 0;
         end
         REG_DAMPING: damp_reg = data[15:0];
         REG_DRY_GAIN: dry_reg = data;
         REG_WET_GAIN: wet_reg = data;
         default: ;
      endcase
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(0, 5))
         0, 1: return sample_type'($urandom);
         2: return $urandom_range(0, 1) ? sample_type'({1'b0, {(SW-1){1'b1}}})
                                        : sample_type'({1'b1, {(SW-1){1'b0}}});
         default: return sample_type'($signed($urandom) >>> $urandom_range(8, 20));
      endcase
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 8);
   endfunction

   // Clock and reset.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Input driver: one word from the pending queue at a time.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            reverb_step(req_left_sample, req_right_sample);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               req_left_sample <= next_word.left;
               req_right_sample <= next_word.right;
               next_valid = 1'b1;
               if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
               send_gap = draw_wait(send_burst);
            end
         end
         req_valid <= next_valid;
      end
   end

   // Output monitor: compare each accepted word with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: left %0d right %0d", rsp_left_out, rsp_right_out);
            end else begin
               seen_word = expected_outs.pop_front();
               if (rsp_left_out !== seen_word.left || rsp_right_out !== seen_word.right) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected left %0d right %0d, got left %0d right %0d",
                              seen_word.left, seen_word.right, rsp_left_out, rsp_right_out);
               end
            end
            if ($urandom_range(0, 40) == 0) stall_burst = !stall_burst;
            stall_left = draw_wait(stall_burst);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_register(logic [2:0] idx, logic [16:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic write_lengths(logic [16:0] a, logic [16:0] b, logic [16:0] c,
                                logic [16:0] d);
      write_register(REG_COMB_LEN_ONE, a);
      write_register(REG_COMB_LEN_TWO, b);
      write_register(REG_COMB_LEN_THREE, c);
      write_register(REG_COMB_LEN_FOUR, d);
   endtask

   task automatic write_gains(logic [16:0] damp, logic [16:0] dry, logic [16:0] wet);
      write_register(REG_DAMPING, damp);
      write_register(REG_DRY_GAIN, dry);
      write_register(REG_WET_GAIN, wet);
   endtask

   task automatic queue_random(int count);
      stereo_word_type w;
      for (int n = 0; n < count; n++) begin
         w.left = random_sample();
         w.right = random_sample();
         pending_words.push_back(w);
      end
   endtask

   task automatic queue_pair(sample_type l, sample_type r);
      stereo_word_type w;
      w.left = l;
      w.right = r;
      pending_words.push_back(w);
   endtask

   // Wait until every word has gone through and the pipeline has drained.
   task automatic drain();
      @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_outs.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // Test sequence.
   initial begin
      sample_type smax, smin;
      smax = {1'b0, {(SW-1){1'b1}}};
      smin = {1'b1, {(SW-1){1'b0}}};
      reset = 1'b1;
      req_valid = 1'b0;
      req_left_sample = '0;
      req_right_sample = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_COMB_LEN_ONE;
      csr_data = '0;
      mismatches = 0;
      cycles = 0;
      send_burst = 1'b0;
      stall_burst = 1'b0;
      foreach (comb_mem[a, b]) comb_mem[a][b] = 0;
      foreach (ap_mem[a, b]) ap_mem[a][b] = 0;
      for (int k = 0; k < 4; k++) begin
         comb_pos[k] = 0;
         ap_pos[k] = 0;
      end
      comb_len_reg = '{COMB_LEN_RST_ONE, COMB_LEN_RST_TWO, COMB_LEN_RST_THREE,
                       COMB_LEN_RST_FOUR};
      damp_reg = DAMP_RST;
      dry_reg = GAIN_RST;
      wet_reg = GAIN_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: full-scale and sign corner words first.
      queue_pair(smax, smax);
      queue_pair(smin, smin);
      queue_pair(smax, smin);
      queue_pair(smin, smax);
      queue_pair('0, '0);
      queue_pair(sample_type'(-1), sample_type'(-1));
      queue_pair(sample_type'(1), sample_type'(0));
      queue_pair(sample_type'(-1), sample_type'(0));
      queue_pair(sample_type'(0), sample_type'(-1));
      queue_pair(smax, sample_type'(-1));
      queue_pair(smin, sample_type'(1));
      queue_pair(sample_type'(-1), sample_type'(1));
      queue_random(150);
      drain();

      // Short combs with maximum feedback and unity gains drive saturation.
      write_lengths(17'(1), 17'(2), 17'(3), 17'(5));
      write_gains(17'(DAMP_MAX), GAIN_UNITY, GAIN_UNITY);
      queue_random(300);
      drain();

      // Out-of-range lengths and gains clamp.
      write_lengths(17'(0), 17'h3fff, 17'(COMB_DEPTH_DEF), 17'(7));
      write_gains(17'h0ffff, 17'h1ffff, 17'(0));
      queue_random(250);
      drain();

      // Unused index is ignored; zero feedback and dry path.
      write_register(REG_UNUSED, 17'($urandom));
      write_lengths(17'(13), 17'(29), 17'(64), 17'(100));
      write_gains(17'(0), 17'(0), 17'h1ffff);
      queue_random(300);
      drain();

      // Random legal settings, mostly short combs.
      for (int ph = 0; ph < 3; ph++) begin
         write_lengths(17'($urandom_range(1, 300)), 17'($urandom_range(1, 300)),
                       17'($urandom_range(1, 300)),
                       17'($urandom_range(1, COMB_DEPTH_DEF)));
         write_gains(17'($urandom_range(0, DAMP_MAX)), 17'($urandom_range(0, GAIN_UNITY)),
                     17'($urandom_range(0, GAIN_UNITY)));
         queue_random(250);
         drain();
      end

      mismatches += expected_outs.size();
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
